/* src/euler_scale_transform_matrix_macros.svh */
// Assertion macros shared by the transform matrix RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef EULER_SCALE_TRANSFORM_MATRIX_MACROS_SVH
`define EULER_SCALE_TRANSFORM_MATRIX_MACROS_SVH

`ifndef ASSERT_OFF
`define EST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("transform matrix check failed");
`define EST_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("transform matrix forbidden condition seen");
`else
`define EST_ASSERT(lbl, clk, rst, prop)
`define EST_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

/* src/est_pkg.sv */
// Shared constants, widths and types of the transform matrix block.
// No dependencies.
package est_pkg;

   localparam int ANG_W   = 16;
   localparam int SCALE_W = 16;
   localparam int TRANS_W = 32;
   localparam int ELEM_W  = 32;
   localparam int COL_W   = 2;

   localparam int PHASE_W = 16;
   localparam logic [17:0] ANG_TO_PHASE = 18'd166886;

   localparam int TRIG_W = 16;
   localparam logic [14:0] POLY_A = 15'd25736;
   localparam logic [13:0] POLY_B = 14'd10512;
   localparam logic [10:0] POLY_C = 11'd1160;
   localparam logic [14:0] Q14_ONE = 15'd16384;

   localparam int PAIR_W = 2 * TRIG_W;
   localparam int TRIP_W = PAIR_W + TRIG_W;
   localparam int ROT_W  = 45;

   localparam int DIV_W      = 27;
   localparam int DIV_BITS   = 3;
   localparam int DIV_STAGES = DIV_W / DIV_BITS;
   localparam int REM_W      = SCALE_W + 1;

   localparam int SC_LAT    = 5;
   localparam int ROT_LAT   = 2;
   localparam int FRONT_LAT = SC_LAT + ROT_LAT;
   localparam int ELEM_LAT  = DIV_STAGES + 1;
   localparam int PIPE_LAT  = FRONT_LAT + ELEM_LAT;

   localparam logic CMD_MODEL  = 1'b0;
   localparam logic CMD_NORMAL = 1'b1;

   localparam logic [COL_W-1:0] COL_0     = 2'd0;
   localparam logic [COL_W-1:0] COL_1     = 2'd1;
   localparam logic [COL_W-1:0] COL_2     = 2'd2;
   localparam logic [COL_W-1:0] COL_TRANS = 2'd3;

   localparam logic signed [ELEM_W-1:0] ONE_Q16  = 32'sh0001_0000;
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;

   typedef logic signed [ROT_W-1:0] rot_type;

   typedef struct packed {
      logic                     zero;
      logic signed [ELEM_W-1:0] value;
   } elem_out_type;

endpackage

/* src/est_channel_if.sv */
// Handshake channels of the transform matrix block: request and response.
// Depends on est_pkg for field widths.
interface est_req_if import est_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic signed [ANG_W-1:0]   rot_x;
   logic signed [ANG_W-1:0]   rot_y;
   logic signed [ANG_W-1:0]   rot_z;
   logic signed [SCALE_W-1:0] scale_x;
   logic signed [SCALE_W-1:0] scale_y;
   logic signed [SCALE_W-1:0] scale_z;
   logic signed [TRANS_W-1:0] trans_x;
   logic signed [TRANS_W-1:0] trans_y;
   logic signed [TRANS_W-1:0] trans_z;

   modport source (output valid, command, rot_x, rot_y, rot_z, scale_x, scale_y, scale_z,
                   trans_x, trans_y, trans_z, input ready);
   modport sink (input valid, command, rot_x, rot_y, rot_z, scale_x, scale_y, scale_z,
                 trans_x, trans_y, trans_z, output ready);
endinterface

interface est_rsp_if import est_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [COL_W-1:0]         column;
   logic signed [ELEM_W-1:0] elem_x;
   logic signed [ELEM_W-1:0] elem_y;
   logic signed [ELEM_W-1:0] elem_z;
   logic signed [ELEM_W-1:0] elem_w;
   logic                     zero_scale;
   logic                     last;

   modport source (output valid, column, elem_x, elem_y, elem_z, elem_w, zero_scale, last,
                   input ready);
   modport sink (input valid, column, elem_x, elem_y, elem_z, elem_w, zero_scale, last,
                 output ready);
endinterface

/* src/est_sincos.sv */
// Sine/cosine lane: angle to phase, then a 4-stage polynomial per output.
// Depends on est_pkg. Advances on en.
module est_sincos import est_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [ANG_W-1:0]  angle,
   output logic signed [TRIG_W-1:0] sin_out,
   output logic signed [TRIG_W-1:0] cos_out
);

   logic signed [34:0]   phase_prod;
   logic [31:0]          phase_rnd;
   logic [PHASE_W-1:0]   phase_in, phase_ff;

   logic [1:0]  quad_a_in [2], quad_a_ff [2];
   logic [14:0] t_a_in [2], t_a_ff [2];
   logic [14:0] tsq_a_in [2], tsq_a_ff [2];

   logic [1:0]  quad_b_ff [2];
   logic [14:0] t_b_ff [2];
   logic [14:0] tsq_b_ff [2];
   logic [13:0] inner_b_in [2], inner_b_ff [2];

   logic [1:0]  quad_c_ff [2];
   logic [14:0] t_c_ff [2];
   logic [14:0] mid_c_in [2], mid_c_ff [2];

   logic signed [TRIG_W-1:0] trig_in [2], trig_ff [2];

   always_comb begin
      phase_prod = angle * $signed({1'b0, ANG_TO_PHASE});
      phase_rnd  = phase_prod[31:0] + 32'h0000_8000;
      phase_in   = phase_rnd[31:16];
   end

   always_comb begin
      logic [PHASE_W-1:0] ph;
      logic [29:0] tt;
      logic [24:0] ct;
      logic [24:0] ctr;
      logic [28:0] pr;
      logic [28:0] prr;
      logic [29:0] ps;
      logic [29:0] psr;
      logic [14:0] smag;
      for (int i = 0; i < 2; i++) begin
         ph = (i == 0) ? phase_ff : phase_ff + 16'h4000;
         quad_a_in[i] = ph[15:14];
         t_a_in[i] = ph[14] ? 15'(Q14_ONE - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
         tt = 30'(t_a_in[i]) * 30'(t_a_in[i]);
         tt = (tt + 30'd8192) >> 14;
         tsq_a_in[i] = tt[14:0];

         ct  = 25'(POLY_C) * 25'(tsq_a_ff[i]);
         ctr = (ct + 25'd8192) >> 14;
         inner_b_in[i] = POLY_B - ctr[13:0];

         pr  = 29'(tsq_b_ff[i]) * 29'(inner_b_ff[i]);
         prr = (pr + 29'd8192) >> 14;
         mid_c_in[i] = POLY_A - {1'b0, prr[13:0]};

         ps   = 30'(t_c_ff[i]) * 30'(mid_c_ff[i]);
         psr  = (ps + 30'd8192) >> 14;
         smag = (psr[14:0] > Q14_ONE) ? Q14_ONE : psr[14:0];
         trig_in[i] = quad_c_ff[i][1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff <= phase_in;
         for (int i = 0; i < 2; i++) begin
            quad_a_ff[i]  <= quad_a_in[i];
            t_a_ff[i]     <= t_a_in[i];
            tsq_a_ff[i]   <= tsq_a_in[i];
            quad_b_ff[i]  <= quad_a_ff[i];
            t_b_ff[i]     <= t_a_ff[i];
            tsq_b_ff[i]   <= tsq_a_ff[i];
            inner_b_ff[i] <= inner_b_in[i];
            quad_c_ff[i]  <= quad_b_ff[i];
            t_c_ff[i]     <= t_b_ff[i];
            mid_c_ff[i]   <= mid_c_in[i];
            trig_ff[i]    <= trig_in[i];
         end
      end
   end

   assign sin_out = trig_ff[0];
   assign cos_out = trig_ff[1];

endmodule

/* src/est_rot.sv */
// Rotation basis from Y-X-Z sines and cosines, exact Q42 entries.
// Depends on est_pkg. Advances on en.
module est_rot import est_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [TRIG_W-1:0] s1,
   input  logic signed [TRIG_W-1:0] c1,
   input  logic signed [TRIG_W-1:0] s2,
   input  logic signed [TRIG_W-1:0] c2,
   input  logic signed [TRIG_W-1:0] s3,
   input  logic signed [TRIG_W-1:0] c3,
   output rot_type                  rot [3][3]
);

   logic signed [PAIR_W-1:0] c1c3_ff, s1s2_ff, c2s3_ff, c1s2_ff, c3s1_ff;
   logic signed [PAIR_W-1:0] c1s3_ff, c2c3_ff, s1s3_ff, c2s1_ff, c1c2_ff;
   logic signed [TRIG_W-1:0] s2_ff, s3_ff;
   rot_type rot_in [3][3];
   rot_type rot_ff [3][3];

   function automatic logic signed [TRIP_W-1:0] sh14(input logic signed [PAIR_W-1:0] p);
      sh14 = TRIP_W'(p) <<< 14;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         c1c3_ff <= c1 * c3;
         s1s2_ff <= s1 * s2;
         c2s3_ff <= c2 * s3;
         c1s2_ff <= c1 * s2;
         c3s1_ff <= c3 * s1;
         c1s3_ff <= c1 * s3;
         c2c3_ff <= c2 * c3;
         s1s3_ff <= s1 * s3;
         c2s1_ff <= c2 * s1;
         c1c2_ff <= c1 * c2;
         s2_ff   <= s2;
         s3_ff   <= s3;
      end
   end

   always_comb begin
      logic signed [TRIP_W-1:0] m_a, m_b, m_c, m_d;
      m_a = s1s2_ff * s3_ff;
      m_b = c1s2_ff * s3_ff;
      m_c = c3s1_ff * s2_ff;
      m_d = c1c3_ff * s2_ff;
      rot_in[0][0] = ROT_W'(sh14(c1c3_ff) + m_a);
      rot_in[0][1] = ROT_W'(sh14(c2s3_ff));
      rot_in[0][2] = ROT_W'(m_b - sh14(c3s1_ff));
      rot_in[1][0] = ROT_W'(m_c - sh14(c1s3_ff));
      rot_in[1][1] = ROT_W'(sh14(c2c3_ff));
      rot_in[1][2] = ROT_W'(m_d + sh14(s1s3_ff));
      rot_in[2][0] = ROT_W'(sh14(c2s1_ff));
      rot_in[2][1] = ROT_W'(-(TRIP_W'(s2_ff) <<< 28));
      rot_in[2][2] = ROT_W'(sh14(c1c2_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff <= rot_in;
      end
   end

   assign rot = rot_ff;

endmodule

/* src/est_elem.sv */
// Element lane: scaled (model) or divided (normal) rotation entry.
// Depends on est_pkg. Pipelined restoring divider.
module est_elem import est_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic                      mode,
   input  rot_type                   rot,
   input  logic signed [SCALE_W-1:0] scale,
   output elem_out_type              result
);

   typedef struct packed {
      logic                     mode;
      logic signed [ELEM_W-1:0] model_val;
      logic [DIV_W-1:0]         dvd;
      logic [REM_W-1:0]         rem;
      logic [SCALE_W-1:0]       dvs;
      logic                     neg;
      logic                     zero;
      logic                     rpos;
      logic                     rneg;
   } div_stage_type;

   div_stage_type stage_ff [DIV_STAGES+1];
   div_stage_type prep_in;

   always_comb begin
      logic signed [ROT_W+SCALE_W-1:0] mp;
      logic signed [ROT_W+SCALE_W-1:0] msh;
      logic [ROT_W-1:0]                num;
      logic [ROT_W:0]                  x;
      mp  = rot * scale;
      msh = (mp + $signed((ROT_W+SCALE_W)'(64'h2_0000_0000))) >>> 34;
      num = rot[ROT_W-1] ? ROT_W'(-rot) : rot;
      prep_in.mode      = mode;
      prep_in.model_val = msh[ELEM_W-1:0];
      prep_in.dvs       = scale[SCALE_W-1] ? SCALE_W'(-scale) : scale;
      x = (ROT_W+1)'(num) + ((ROT_W+1)'(prep_in.dvs) << 17);
      prep_in.dvd  = x[18 +: DIV_W];
      prep_in.rem  = '0;
      prep_in.neg  = rot[ROT_W-1] ^ scale[SCALE_W-1];
      prep_in.zero = (scale == '0);
      prep_in.rpos = !rot[ROT_W-1] && (rot != '0);
      prep_in.rneg = rot[ROT_W-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= prep_in;
      end
   end

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      div_stage_type stage_in;
      always_comb begin
         stage_in = stage_ff[j];
         for (int b = 0; b < DIV_BITS; b++) begin
            stage_in.rem = {stage_in.rem[REM_W-2:0], stage_in.dvd[DIV_W-1]};
            stage_in.dvd = {stage_in.dvd[DIV_W-2:0], 1'b0};
            if (stage_in.rem >= {1'b0, stage_in.dvs}) begin
               stage_in.rem    = stage_in.rem - {1'b0, stage_in.dvs};
               stage_in.dvd[0] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[j+1] <= stage_in;
         end
      end
   end

   always_comb begin
      div_stage_type fin;
      logic signed [ELEM_W-1:0] q;
      fin = stage_ff[DIV_STAGES];
      q   = $signed(ELEM_W'(fin.dvd));
      result.zero = (fin.mode == CMD_NORMAL) && fin.zero;
      if (fin.mode == CMD_MODEL) begin
         result.value = fin.model_val;
      end else if (fin.zero) begin
         result.value = fin.rpos ? ELEM_MAX : (fin.rneg ? ELEM_MIN : '0);
      end else begin
         result.value = fin.neg ? -q : q;
      end
   end

endmodule

/* src/euler_scale_transform_matrix.sv */
// Top level of the Y-X-Z Euler rotation, scale and translation matrix block.
// Depends on est_pkg, est_channel_if, est_sincos, est_rot, est_elem and the macros header.
`include "euler_scale_transform_matrix_macros.svh"

// A transaction enters a 17-stage pipeline (5 for sine/cosine, 2 for the rotation
// basis, 10 for scaling and the pipelined divider) and may enter every cycle the
// pipeline is not held. Its columns then leave one per cycle from an output buffer
// while the response channel is ready: 4 in model mode, 3 in normal mode, so the
// single response channel sets the sustained transaction rate. While the buffer
// still holds columns the next finished transaction waits in the last stage and
// the pipeline holds.
module euler_scale_transform_matrix import est_pkg::*; (
   input logic      clock,
   input logic      reset,
   est_req_if.sink  req,
   est_rsp_if.source rsp
);

   typedef struct packed {
      logic                          cmd;
      logic [2:0][TRANS_W-1:0]       trans;
   } side_type;

   logic pipe_adv, load, rsp_fire;
   logic [PIPE_LAT-1:0] vld_ff;
   side_type side_ff [PIPE_LAT];
   logic signed [SCALE_W-1:0] scale_ff [FRONT_LAT][3];

   logic signed [TRIG_W-1:0] sy, cy, sx, cx, sz, cz;
   rot_type rot_w [3][3];
   elem_out_type elem_w [3][3];

   logic                     buf_valid_ff;
   logic [COL_W-1:0]         col_ff;
   logic                     buf_cmd_ff;
   logic signed [ELEM_W-1:0] buf_elem_ff [3][3];
   logic                     buf_zero_ff [3];
   logic [2:0][TRANS_W-1:0]  buf_trans_ff;

   assign rsp_fire = rsp.valid && rsp.ready;
   assign load     = vld_ff[PIPE_LAT-1] && (!buf_valid_ff || (rsp_fire && rsp.last));
   assign pipe_adv = !vld_ff[PIPE_LAT-1] || load;
   assign req.ready = pipe_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_adv) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         side_ff[0].cmd   <= req.command;
         side_ff[0].trans <= {req.trans_z, req.trans_y, req.trans_x};
         for (int i = 1; i < PIPE_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         scale_ff[0][0] <= req.scale_x;
         scale_ff[0][1] <= req.scale_y;
         scale_ff[0][2] <= req.scale_z;
         for (int i = 1; i < FRONT_LAT; i++) begin
            scale_ff[i] <= scale_ff[i-1];
         end
      end
   end

   est_sincos u_sc_y (.clock(clock), .en(pipe_adv), .angle(req.rot_y), .sin_out(sy),
                      .cos_out(cy));
   est_sincos u_sc_x (.clock(clock), .en(pipe_adv), .angle(req.rot_x), .sin_out(sx),
                      .cos_out(cx));
   est_sincos u_sc_z (.clock(clock), .en(pipe_adv), .angle(req.rot_z), .sin_out(sz),
                      .cos_out(cz));

   est_rot u_rot (
      .clock(clock), .en(pipe_adv),
      .s1(sy), .c1(cy), .s2(sx), .c2(cx), .s3(sz), .c3(cz),
      .rot(rot_w)
   );

   for (genvar c = 0; c < 3; c++) begin : g_col
      for (genvar k = 0; k < 3; k++) begin : g_elem
         est_elem u_elem (
            .clock(clock), .en(pipe_adv),
            .mode(side_ff[FRONT_LAT-1].cmd),
            .rot(rot_w[c][k]),
            .scale(scale_ff[FRONT_LAT-1][c]),
            .result(elem_w[c][k])
         );
      end
   end

   // output buffer walks the columns of one transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         col_ff       <= COL_0;
      end else if (load) begin
         buf_valid_ff <= 1'b1;
         col_ff       <= COL_0;
      end else if (rsp_fire) begin
         buf_valid_ff <= !rsp.last;
         col_ff       <= col_ff + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_cmd_ff   <= side_ff[PIPE_LAT-1].cmd;
         buf_trans_ff <= side_ff[PIPE_LAT-1].trans;
         for (int c = 0; c < 3; c++) begin
            buf_zero_ff[c] <= elem_w[c][0].zero;
            for (int k = 0; k < 3; k++) begin
               buf_elem_ff[c][k] <= elem_w[c][k].value;
            end
         end
      end
   end

   assign rsp.valid  = buf_valid_ff;
   assign rsp.column = col_ff;
   assign rsp.last   = (col_ff == COL_TRANS) ||
                       ((col_ff == COL_2) && (buf_cmd_ff == CMD_NORMAL));

   always_comb begin
      case (col_ff)
         COL_0, COL_1, COL_2: begin
            rsp.elem_x     = buf_elem_ff[col_ff][0];
            rsp.elem_y     = buf_elem_ff[col_ff][1];
            rsp.elem_z     = buf_elem_ff[col_ff][2];
            rsp.elem_w     = '0;
            rsp.zero_scale = buf_zero_ff[col_ff];
         end
         default: begin
            rsp.elem_x     = $signed(buf_trans_ff[0]);
            rsp.elem_y     = $signed(buf_trans_ff[1]);
            rsp.elem_z     = $signed(buf_trans_ff[2]);
            rsp.elem_w     = ONE_Q16;
            rsp.zero_scale = 1'b0;
         end
      endcase
   end

   `EST_ASSERT(a_more_columns, clock, reset, (rsp.valid && rsp.ready && !rsp.last) |=> rsp.valid)
   `EST_ASSERT_NEVER(a_trans_normal, clock, reset, rsp.valid && (col_ff == COL_TRANS) && (buf_cmd_ff == CMD_NORMAL))
   `EST_ASSERT_NEVER(a_zero_model, clock, reset, rsp.valid && rsp.zero_scale && (buf_cmd_ff == CMD_MODEL))
   `EST_ASSERT(a_hold_cause, clock, reset, !pipe_adv |-> (vld_ff[PIPE_LAT-1] && buf_valid_ff))

endmodule
